FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; clock and reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sha1md_pkg.sv
// types and constants for the sha-1 message digest block
// no dependencies; imported by the controller, the datapath and the top level
package sha1md_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       msg_last;
   } req_beat_type;

   typedef struct packed {
      logic [63:0] digest_high;
      logic [63:0] digest_middle;
      logic [31:0] digest_low;
   } rsp_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_INPUT,
      SEL_MARK,
      SEL_ZERO,
      SEL_LENGTH
   } byte_sel_type;

   typedef struct packed {
      logic         push;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         load_work;
      logic         round;
      logic [6:0]   round_idx;
      logic         update_hash;
      logic         count_byte;
      logic         finish;
   } cmd_type;

   localparam logic [31:0] H_INIT [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [6:0] NUM_ROUNDS = 7'd80;

endpackage

FILE: rtl/sha1_message_digest.sv
// sha-1 digest engine fed at most one message byte per beat; one digest beat per message.
// a beat that does not complete a 64-byte block is accepted without a stall; one that
// completes it is followed by 80 rounds of the single round unit plus the hash add, with
// requests stalled. finishing pushes the pad bytes, then runs the rounds and hash add for
// each padded block. synchronous reset loads the initial hash values and clears all
// counters; nothing else needs clearing.
`include "assert_macros.svh"

module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_beat
);

   cmd_type ctrl_cmd;

   sha1md_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .byte_valid (req_beat.byte_valid),
      .msg_last   (req_beat.msg_last),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (ctrl_cmd)
   );

   sha1md_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctrl_cmd),
      .data_byte (req_beat.data_byte),
      .digest    (rsp_beat)
   );

   `ASSERT_ALWAYS(a_no_req_while_rsp, clock, reset, !rsp_valid || req_stall, "request taken while digest pending")
   `ASSERT_ALWAYS(a_round_in_range, clock, reset, !ctrl_cmd.round || ctrl_cmd.round_idx < NUM_ROUNDS, "round index out of range")
   `ASSERT_ALWAYS(a_round_blocks_push, clock, reset, !(ctrl_cmd.round && ctrl_cmd.push), "byte pushed during rounds")
   `ASSERT_NEXT(a_idle_after_rsp, clock, reset, rsp_valid && !rsp_stall, !rsp_valid && !req_stall, "not idle after digest beat")

endmodule

FILE: rtl/sha1md_ctrl.sv
// controller for the sha-1 digest block: byte slot tracking, padding and round sequencing
// depends on sha1md_pkg
module sha1md_ctrl
   import sha1md_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    byte_valid,
   input  logic    msg_last,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [5:0] pos_ff, pos_in;
   logic [6:0] rnd_ff, rnd_in;
   logic       final_ff, final_in;
   logic       mark_ff, mark_in;
   logic       lenph_ff, lenph_in;
   logic       done_ff, done_in;
   logic       req_accept;
   logic       fills;

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.byte_sel = SEL_INPUT;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      req_accept = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            req_accept = req_valid;
            cmd.push   = req_valid && byte_valid;
            cmd.count_byte = req_valid && byte_valid;
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            if (!mark_ff) begin
               cmd.byte_sel = SEL_MARK;
            end else if (lenph_ff || pos_ff == LEN_POS) begin
               cmd.byte_sel = SEL_LENGTH;
            end else begin
               cmd.byte_sel = SEL_ZERO;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update_hash = 1'b1;
         end
         ST_OUTPUT: begin
            rsp_valid  = 1'b1;
            cmd.finish = !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      cmd.len_idx   = pos_ff[2:0];
      cmd.round_idx = rnd_ff;
      cmd.load_work = cmd.push && pos_ff == LAST_POS;
   end

   assign fills = cmd.load_work;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (fills) begin
                  state_in = ST_ROUND;
               end else if (msg_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fills) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (done_ff) begin
               state_in = ST_OUTPUT;
            end else if (final_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // counters and padding flags
   always_comb begin
      pos_in   = cmd.push ? pos_ff + 6'd1 : pos_ff;
      rnd_in   = (state_ff == ST_ROUND) ? rnd_ff + 7'd1 : '0;
      final_in = final_ff || (req_accept && msg_last);
      mark_in  = mark_ff || (cmd.push && cmd.byte_sel == SEL_MARK);
      lenph_in = lenph_ff || (cmd.push && cmd.byte_sel == SEL_LENGTH);
      // the length byte in the last slot closes the final block
      done_in  = done_ff || (fills && cmd.byte_sel == SEL_LENGTH);
      if (cmd.finish) begin
         pos_in   = '0;
         final_in = 1'b0;
         mark_in  = 1'b0;
         lenph_in = 1'b0;
         done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         rnd_ff   <= '0;
         final_ff <= 1'b0;
         mark_ff  <= 1'b0;
         lenph_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
         final_ff <= final_in;
         mark_ff  <= mark_in;
         lenph_ff <= lenph_in;
         done_ff  <= done_in;
      end
   end

endmodule

FILE: rtl/sha1md_dpath.sv
// datapath for the sha-1 digest block: block shift register, round unit, hash words
// depends on sha1md_pkg; driven by sha1md_ctrl commands
module sha1md_dpath
   import sha1md_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic [7:0]   data_byte,
   output rsp_beat_type digest
);

   logic [511:0] block_ff, block_in;
   logic [31:0]  hash_ff [5];
   logic [31:0]  hash_in [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [63:0]  bits_ff, bits_in;
   logic [7:0]   push_byte;
   logic [5:0]   len_shift;
   logic [31:0]  w_cur, w_new, f_val, k_val;

   function automatic logic [31:0] rol(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {v, v} << n;
      return dbl[63:32];
   endfunction

   // byte fed into the block: message, pad marker, zero fill or length
   always_comb begin
      len_shift = {3'(3'd7 - cmd.len_idx), 3'b000};
      case (cmd.byte_sel)
         SEL_INPUT:  push_byte = data_byte;
         SEL_MARK:   push_byte = PAD_MARK;
         SEL_ZERO:   push_byte = '0;
         SEL_LENGTH: push_byte = 8'(bits_ff >> len_shift);
         default:    push_byte = '0;
      endcase
   end

   // window top word is w[t]; next schedule word from taps 13, 8, 2, 0
   assign w_cur = block_ff[511:480];
   assign w_new = rol(block_ff[95:64] ^ block_ff[255:224] ^ block_ff[447:416] ^ w_cur, 5'd1);

   always_comb begin
      case (cmd.round_idx) inside
         [7'd0:7'd19]: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = K_ROUND0;
         end
         [7'd20:7'd39]: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_ROUND1;
         end
         [7'd40:7'd59]: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_ROUND2;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_ROUND3;
         end
      endcase
   end

   always_comb begin
      block_in = block_ff;
      if (cmd.push) begin
         block_in = {block_ff[503:0], push_byte};
      end else if (cmd.round) begin
         block_in = {block_ff[479:0], w_new};
      end

      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.load_work) begin
         a_in = hash_ff[0];
         b_in = hash_ff[1];
         c_in = hash_ff[2];
         d_in = hash_ff[3];
         e_in = hash_ff[4];
      end else if (cmd.round) begin
         a_in = rol(a_ff, 5'd5) + f_val + e_ff + k_val + w_cur;
         b_in = a_ff;
         c_in = rol(b_ff, 5'd30);
         d_in = c_ff;
         e_in = d_ff;
      end

      hash_in = hash_ff;
      if (cmd.finish) begin
         hash_in = H_INIT;
      end else if (cmd.update_hash) begin
         hash_in[0] = hash_ff[0] + a_ff;
         hash_in[1] = hash_ff[1] + b_ff;
         hash_in[2] = hash_ff[2] + c_ff;
         hash_in[3] = hash_ff[3] + d_ff;
         hash_in[4] = hash_ff[4] + e_ff;
      end

      bits_in = bits_ff;
      if (cmd.finish) begin
         bits_in = '0;
      end else if (cmd.count_byte) begin
         bits_in = bits_ff + 64'd8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= H_INIT;
         bits_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
   end

   assign digest.digest_high   = {hash_ff[0], hash_ff[1]};
   assign digest.digest_middle = {hash_ff[2], hash_ff[3]};
   assign digest.digest_low    = hash_ff[4];

endmodule

FILE: tb/sha1_digest_checker.sv
// watches both channels of the sha-1 digest block, predicts each digest and compares
// depends on sha1md_pkg for the beat types and the hash constants
module sha1_digest_checker
   import sha1md_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_beat_type req_beat,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_beat_type rsp_beat,
   output int           mismatches,
   output int           digests_pending
);

   logic [31:0]  hash_words [5];
   logic [31:0]  msg_words [16];
   logic [63:0]  bit_count;
   logic [5:0]   byte_slot;
   rsp_beat_type digest_queue [$];
   rsp_beat_type want;

   task automatic restart_message();
      int i;
      for (i = 0; i < 5; i++) hash_words[i] = H_INIT[i];
      bit_count = '0;
      byte_slot = '0;
   endtask

   task automatic compress_block();
      logic [31:0] a, b, c, d, e, f, k, w, sum;
      int t;
      a = hash_words[0];
      b = hash_words[1];
      c = hash_words[2];
      d = hash_words[3];
      e = hash_words[4];
      for (t = 0; t < 80; t++) begin
         // expand the schedule in place over the 16-word window
         if (t >= 16) begin
            w = msg_words[(t - 3) & 15] ^ msg_words[(t - 8) & 15]
              ^ msg_words[(t - 14) & 15] ^ msg_words[t & 15];
            msg_words[t & 15] = {w[30:0], w[31]};
         end
         w = msg_words[t & 15];
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         sum = {a[26:0], a[31:27]} + f + e + k + w;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      hash_words[0] += a;
      hash_words[1] += b;
      hash_words[2] += c;
      hash_words[3] += d;
      hash_words[4] += e;
   endtask

   task automatic place_byte(input logic [7:0] value);
      int word_idx;
      int lane;
      word_idx = byte_slot[5:2];
      lane = 3 - byte_slot[1:0];
      if (byte_slot[1:0] == 2'd0) msg_words[word_idx] = {value, 24'h000000};
      else msg_words[word_idx][lane * 8 +: 8] = value;
      byte_slot = byte_slot + 6'd1;
      if (byte_slot == 6'd0) compress_block();
   endtask

   task automatic absorb_beat(input req_beat_type beat);
      logic [63:0]  length_bits;
      rsp_beat_type digest;
      int i;
      if (beat.byte_valid) begin
         place_byte(beat.data_byte);
         bit_count += 64'd8;
      end
      if (beat.msg_last) begin
         length_bits = bit_count;
         place_byte(PAD_MARK);
         while (byte_slot != LEN_POS) place_byte(8'h00);
         for (i = 7; i >= 0; i--) place_byte(length_bits[i * 8 +: 8]);
         digest.digest_high   = {hash_words[0], hash_words[1]};
         digest.digest_middle = {hash_words[2], hash_words[3]};
         digest.digest_low    = hash_words[4];
         digest_queue.push_back(digest);
         restart_message();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         digest_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: digest beat expected none actual %h", $time, rsp_beat);
               mismatches++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_beat.digest_high !== want.digest_high) begin
                  $display("%0t: digest_high expected %h actual %h",
                           $time, want.digest_high, rsp_beat.digest_high);
                  mismatches++;
               end
               if (rsp_beat.digest_middle !== want.digest_middle) begin
                  $display("%0t: digest_middle expected %h actual %h",
                           $time, want.digest_middle, rsp_beat.digest_middle);
                  mismatches++;
               end
               if (rsp_beat.digest_low !== want.digest_low) begin
                  $display("%0t: digest_low expected %h actual %h",
                           $time, want.digest_low, rsp_beat.digest_low);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) absorb_beat(req_beat);
      end
      digests_pending <= digest_queue.size();
   end

endmodule

FILE: tb/tb_sha1_message_digest.sv
// stimulus and verdict for the sha-1 digest block; byte streams with random gaps and stalls
// depends on sha1md_pkg, sha1_message_digest and sha1_digest_checker
module tb_sha1_message_digest;
   import sha1md_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int LONG_HOLD    = 600;
   localparam int RANDOM_ITEMS = 1000;
   localparam int MIN_MESSAGES = 25;
   localparam int TAIL_CYCLES  = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_beat = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_beat;
   int           mismatches;
   int           digests_pending;
   int           items_sent;
   int           messages_sent;
   int           idle_cycles;
   bit           no_gaps;

   sha1_message_digest u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   sha1_digest_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_beat        (req_beat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_beat        (rsp_beat),
      .mismatches      (mismatches),
      .digests_pending (digests_pending)
   );

   always #5 clock = ~clock;

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // lengths around the pad and block boundaries
   function automatic int boundary_length();
      case ($urandom_range(0, 8))
         0: return 55;
         1: return 56;
         2: return 57;
         3: return 63;
         4: return 64;
         5: return 65;
         6: return 119;
         7: return 120;
         default: return 128;
      endcase
   endfunction

   function automatic req_beat_type make_beat(input logic [7:0] value, input logic valid_bit,
                                              input logic last_bit);
      req_beat_type beat;
      beat.data_byte  = value;
      beat.byte_valid = valid_bit;
      beat.msg_last   = last_bit;
      return beat;
   endfunction

   task automatic send_beat(input req_beat_type beat);
      int gap;
      gap = no_gaps ? 0 : draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_message(input int length, input bit empty_tail, input int idle_pct);
      int n;
      for (n = 0; n < length; n++) begin
         if ($urandom_range(0, 99) < idle_pct)
            send_beat(make_beat(8'($urandom), 1'b0, 1'b0));
         send_beat(make_beat(8'($urandom), 1'b1, !empty_tail && n == length - 1));
         items_sent++;
      end
      if (empty_tail || length == 0) begin
         send_beat(make_beat(8'($urandom), 1'b0, 1'b1));
         items_sent++;
      end
      messages_sent++;
   endtask

   initial begin : stimulus
      int r;
      int length;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // lone idle beat, then the empty message
      send_beat(make_beat(8'hFF, 1'b0, 1'b0));
      send_beat(make_beat(8'h00, 1'b0, 1'b1));
      // three bytes, last flag on the final byte
      send_beat(make_beat(8'h61, 1'b1, 1'b0));
      send_beat(make_beat(8'h62, 1'b1, 1'b0));
      send_beat(make_beat(8'h63, 1'b1, 1'b1));
      // idle beat inside a message, closed by an empty tail
      send_beat(make_beat(8'hFF, 1'b1, 1'b0));
      send_beat(make_beat(8'h5A, 1'b0, 1'b0));
      send_beat(make_beat(8'h00, 1'b1, 1'b0));
      send_beat(make_beat(8'hA5, 1'b0, 1'b1));
      // single-byte messages at the byte extremes, then empty again
      send_beat(make_beat(8'h00, 1'b1, 1'b1));
      send_beat(make_beat(8'hFF, 1'b1, 1'b1));
      send_beat(make_beat(8'hFF, 1'b0, 1'b1));

      items_sent = 0;
      messages_sent = 0;
      while (items_sent < RANDOM_ITEMS || messages_sent < MIN_MESSAGES) begin
         r = $urandom_range(0, 99);
         if (r < 65) length = $urandom_range(0, 16);
         else if (r < 88) length = boundary_length();
         else length = $urandom_range(17, 140);
         no_gaps = ($urandom_range(0, 3) == 0);
         send_message(length, 1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0) ? 10 : 0);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (digests_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && digests_pending == 0)
         $display("sha1_message_digest verification clean");
      else
         $display("sha1_message_digest verification failed");
      $finish;
   end

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin : receiver
      int taken;
      int left;
      bit held_off;
      taken = 0;
      left = 0;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) taken++;
         if (left > 0) begin
            left--;
         end else if (!held_off && taken >= 8) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            left = LONG_HOLD;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 15);
         end else begin
            rsp_stall <= 1'b1;
            left = draw_gap();
         end
      end
   end

   // watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("sha1_message_digest verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
